// File: design/fdp_pkg.sv
// Package with binary32 types and the rounding, multiply and add functions.
`timescale 1ns / 1ps
package fdp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned SigW  = 48;
  localparam int unsigned ExpW  = 12;

  typedef struct packed {
    logic [WordW-1:0] bits;
    logic             ovf;
  } fp_res_t;

  // Round a wide significand to binary32 with round-to-nearest-even.
  // Bit SigW-1 of sig weighs 2^(x-127).
  function automatic fp_res_t round_pack(input logic sgn, input logic signed [ExpW-1:0] x,
                                         input logic [SigW-1:0] sig);
    fp_res_t                res;
    logic [5:0]             lz;
    logic                   found;
    logic signed [ExpW-1:0] xn;
    logic [SigW-1:0]        sn;
    logic [SigW-1:0]        sh;
    logic [ExpW-1:0]        rs;
    logic                   stk;
    logic [23:0]            m24;
    logic                   grd;
    logic                   rup;
    logic [7:0]             expf;
    logic [30:0]            packed_v;
    lz    = '0;
    found = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!found && sig[i]) begin
        found = 1'b1;
        lz    = 6'(SigW - 1 - i);
      end
    end
    sn  = sig << lz;
    xn  = x - ExpW'(signed'({1'b0, lz}));
    sh  = sn;
    stk = 1'b0;
    if (xn < 1) begin
      rs = ExpW'(1 - xn);
      if (rs >= ExpW'(SigW)) begin
        sh  = '0;
        stk = |sn;
      end else begin
        sh  = sn >> rs;
        stk = |(sn & ((SigW'(1) << rs) - SigW'(1)));
      end
      xn = ExpW'(1);
    end
    m24      = sh[SigW-1 -: 24];
    grd      = sh[SigW-25];
    stk      = stk | (|sh[SigW-26:0]);
    rup      = grd & (stk | m24[0]);
    expf     = m24[23] ? xn[7:0] : 8'd0;
    packed_v = {expf, m24[22:0]} + 31'(rup);
    res.ovf  = (xn > 254) || (packed_v[30:23] == 8'hFF);
    res.bits = found ? {sgn, packed_v} : {sgn, 31'd0};
    return res;
  endfunction

  function automatic fp_res_t fp_mul(input logic [WordW-1:0] a, input logic [WordW-1:0] b);
    logic [23:0]            ma;
    logic [23:0]            mb;
    logic signed [ExpW-1:0] x;
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    x  = ExpW'(signed'({1'b0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}))
       + ExpW'(signed'({1'b0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]})) - ExpW'(126);
    return round_pack(a[31] ^ b[31], x, ma * mb);
  endfunction

  function automatic fp_res_t fp_add(input logic [WordW-1:0] a, input logic [WordW-1:0] b);
    logic [WordW-1:0]       p;
    logic [WordW-1:0]       q;
    logic [7:0]             ep;
    logic [7:0]             eq;
    logic [7:0]             d;
    logic [SigW-1:0]        sx;
    logic [SigW-1:0]        sy;
    logic [SigW-1:0]        sy_full;
    logic [SigW-1:0]        sum;
    logic                   sgn;
    logic signed [ExpW-1:0] x;
    if (a[30:0] >= b[30:0]) begin
      p = a;
      q = b;
    end else begin
      p = b;
      q = a;
    end
    ep      = (p[30:23] == 8'd0) ? 8'd1 : p[30:23];
    eq      = (q[30:23] == 8'd0) ? 8'd1 : q[30:23];
    d       = ep - eq;
    sx      = {1'b0, |p[30:23], p[22:0], 23'd0};
    sy_full = {1'b0, |q[30:23], q[22:0], 23'd0};
    if (d >= 8'(SigW)) begin
      sy = {{(SigW-1){1'b0}}, |sy_full};
    end else begin
      sy    = sy_full >> d;
      sy[0] = sy[0] | (|(sy_full & ((SigW'(1) << d) - SigW'(1))));
    end
    if (p[31] == q[31]) begin
      sum = sx + sy;
      sgn = p[31];
    end else begin
      sum = sx - sy;
      sgn = (sum == '0) ? 1'b0 : p[31];
    end
    x = ExpW'(signed'({1'b0, ep})) + ExpW'(1);
    return round_pack(sgn, x, sum);
  endfunction

endpackage

// File: design/float_dot_product_checked.sv
// Streaming binary32 dot product with NaN and infinity checking.
// The result of a last element pair passes the product register and then the result register.
// Throughput: one pair per cycle unless a result waits untaken; the sum feeds the adder.
// The multiplier is registered before the accumulating adder.
// Reset (rst_ni low, asynchronous) clears the pipeline, the running sum to +0 and the flags.
// Input ready falls only while a result waits at the output and is not taken.
`timescale 1ns / 1ps
module float_dot_product_checked import fdp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] a_value_i,
  input  logic [WordW-1:0] b_value_i,
  input  logic             last_element_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] dot_value_o,
  output logic             status_o
);

  // The whole pipeline advances together whenever the output register is free or taken.
  logic             adv;
  // Product stage.
  logic             p_valid_q;
  logic             p_last_q;
  logic             p_bad_q;
  logic             p_nf_q;
  logic [WordW-1:0] p_bits_q;
  // Accumulator state: a non-finite sum stays non-finite, so only a flag is kept.
  logic [WordW-1:0] sum_q, sum_d;
  logic             nf_q, nf_d;
  logic             bad_q, bad_d;
  logic             out_valid_q;
  logic [WordW-1:0] dot_q;
  logic             status_q;
  fp_res_t          mul_r;
  fp_res_t          add_r;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign mul_r      = fp_mul(a_value_i, b_value_i);
  assign add_r      = fp_add(sum_q, p_bits_q);

  always_comb begin
    sum_d = add_r.bits;
    nf_d  = nf_q | p_nf_q | add_r.ovf;
    bad_d = bad_q | p_bad_q;
  end

  // Product register: an overflowing product is carried as a non-finite flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_last_q <= last_element_i;
      p_bad_q  <= (a_value_i[30:23] == 8'hFF) || (b_value_i[30:23] == 8'hFF);
      p_nf_q   <= mul_r.ovf;
      p_bits_q <= mul_r.bits;
    end
  end

  // Accumulation and result register. A last pair clears the sum and both flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      nf_q        <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p_valid_q && p_last_q;
      if (p_valid_q) begin
        if (p_last_q) begin
          sum_q <= '0;
          nf_q  <= 1'b0;
          bad_q <= 1'b0;
        end else begin
          sum_q <= sum_d;
          nf_q  <= nf_d;
          bad_q <= bad_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && p_valid_q && p_last_q) begin
      status_q <= nf_d | bad_d;
      dot_q    <= (nf_d | bad_d) ? '0 : sum_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_value_o = dot_q;
  assign status_o    = status_q;

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q |-> dot_q == '0)
    else $error("failed result carries a non-zero value");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && p_valid_q && p_last_q |=> sum_q == '0 && !nf_q && !bad_q)
    else $error("accumulator not cleared after a last pair");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(p_valid_q && p_last_q))
    else $error("result raised without a last pair");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sum_q) && $stable(p_bits_q))
    else $error("pipeline moved while stalled");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the streaming binary32 dot product with NaN and infinity checking.
`timescale 1ns / 1ps

// Records each element pair as it is accepted and works out the expected dot product.
// Each result taken from the output is then checked against the oldest expected result.
class dot_scoreboard;
  typedef struct {
    logic [31:0] value;
    logic        status;
  } dot_result_t;

  logic [31:0] acc_bits;
  logic        nonfinite_seen;
  dot_result_t pending_dots[$];
  int unsigned failures;

  function new();
    acc_bits       = 32'h0000_0000;
    nonfinite_seen = 1'b0;
    failures       = 0;
  endfunction

  function automatic logic is_nonfinite(logic [31:0] w);
    return w[30:23] == 8'hFF;
  endfunction

  // Splits a finite binary32 pattern into an integer significand and a power of two.
  function automatic void split_float(input logic [31:0] w, output logic [23:0] man,
                                      output int ex);
    if (w[30:23] == 8'd0) begin
      man = {1'b0, w[22:0]};
      ex  = -149;
    end else begin
      man = {1'b1, w[22:0]};
      ex  = int'(w[30:23]) - 150;
    end
  endfunction

  // Rounds sgn * mag * 2^ex to binary32 with ties to even.
  function automatic logic [31:0] round_single(input logic sgn, input int ex,
                                               input logic [127:0] mag);
    int           msb;
    int           drop;
    int           qexp;
    logic [255:0] wide;
    logic [255:0] quot;
    logic [255:0] tmp;
    logic         half;
    logic         stk;
    if (mag == '0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 128; i++) begin
      if (mag[i]) msb = i;
    end
    // The quantum is one unit in the last place, but never below the smallest subnormal.
    drop = msb + ex - 23;
    if (drop < -149) drop = -149;
    drop = drop - ex;
    wide = 256'(mag);
    if (drop > 0) begin
      quot = wide >> drop;
      tmp  = wide >> (drop - 1);
      half = tmp[0];
      stk  = |(wide & ((256'(1) << (drop - 1)) - 256'(1)));
      if (half && (stk || quot[0])) quot = quot + 256'(1);
    end else begin
      quot = wide << (-drop);
    end
    qexp = drop + ex;
    if (quot[24]) begin
      quot = quot >> 1;
      qexp = qexp + 1;
    end
    if (!quot[23]) return {sgn, 8'd0, quot[22:0]};
    if (qexp + 150 >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(qexp + 150), quot[22:0]};
  endfunction

  // Only the fact that a non-finite value appears matters here, so a quiet NaN stands in.
  function automatic logic [31:0] mul_single(logic [31:0] x, logic [31:0] y);
    logic [23:0] mx;
    logic [23:0] my;
    int          ex;
    int          ey;
    if (is_nonfinite(x) || is_nonfinite(y)) return 32'h7FC0_0000;
    split_float(x, mx, ex);
    split_float(y, my, ey);
    return round_single(x[31] ^ y[31], ex + ey, 128'(mx) * 128'(my));
  endfunction

  function automatic logic [31:0] add_single(logic [31:0] x, logic [31:0] y);
    logic [31:0]  hi;
    logic [31:0]  lo;
    logic [23:0]  mh;
    logic [23:0]  ml;
    int           eh;
    int           el;
    int           ex;
    logic [127:0] big;
    logic [127:0] sml;
    logic [127:0] mag;
    logic         sgn;
    if (is_nonfinite(x) || is_nonfinite(y)) return 32'h7FC0_0000;
    if (x[30:23] >= y[30:23]) begin
      hi = x;
      lo = y;
    end else begin
      hi = y;
      lo = x;
    end
    split_float(hi, mh, eh);
    split_float(lo, ml, el);
    // A far smaller addend is reduced to a sticky unit well below the rounding position.
    if (eh - el < 100) begin
      big = 128'(mh) << (eh - el);
      sml = 128'(ml);
      ex  = el;
    end else begin
      big = 128'(mh) << 100;
      sml = 128'(ml != 24'd0);
      ex  = eh - 100;
    end
    if (hi[31] == lo[31]) begin
      mag = big + sml;
      sgn = hi[31];
    end else if (big >= sml) begin
      mag = big - sml;
      sgn = hi[31];
    end else begin
      mag = sml - big;
      sgn = lo[31];
    end
    // An exact zero is negative only when both addends are negative zeros.
    if (mag == '0) sgn = hi[31] & lo[31];
    return round_single(sgn, ex, mag);
  endfunction

  function void note_pair(logic [31:0] a, logic [31:0] b, logic last);
    dot_result_t r;
    if (is_nonfinite(a) || is_nonfinite(b)) nonfinite_seen = 1'b1;
    acc_bits = add_single(acc_bits, mul_single(a, b));
    if (last) begin
      if (nonfinite_seen || is_nonfinite(acc_bits)) begin
        r.value  = 32'h0000_0000;
        r.status = 1'b1;
      end else begin
        r.value  = acc_bits;
        r.status = 1'b0;
      end
      pending_dots.push_back(r);
      acc_bits       = 32'h0000_0000;
      nonfinite_seen = 1'b0;
    end
  endfunction

  function void check_result(logic [31:0] value, logic status);
    dot_result_t r;
    if (pending_dots.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: unexpected result value=%h status=%b", $time, value, status);
      return;
    end
    r = pending_dots.pop_front();
    if (value !== r.value || status !== r.status) begin
      failures++;
      if (failures <= 10)
        $display("%0t: mismatch expected value=%h status=%b, got value=%h status=%b",
                 $time, r.value, r.status, value, status);
    end
  endfunction
endclass

module tb_top import fdp_pkg::*;;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [WordW-1:0] a_value_i;
  logic [WordW-1:0] b_value_i;
  logic             last_element_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [WordW-1:0] dot_value_o;
  logic             status_o;

  // Idle chances in percent for the sending and the receiving side of the current phase.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned pairs_sent;

  dot_scoreboard dot_board = new();

  float_dot_product_checked uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .a_value_i     (a_value_i),
    .b_value_i     (b_value_i),
    .last_element_i(last_element_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dot_value_o   (dot_value_o),
    .status_o      (status_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // The receiver decides at each falling edge whether it will take a result at the next rising edge.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Every result transfer is checked at the rising edge on which it happens.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      dot_board.check_result(dot_value_o, status_o);
    end
  end

  // Offers one element pair and holds it steady until the block takes it. Idle cycles
  // in front of the pair are drawn at random so that gaps fall anywhere in a vector.
  task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    a_value_i      <= a;
    b_value_i      <= b;
    last_element_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    dot_board.note_pair(a, b, last);
    pairs_sent++;
  endtask

  // Draws an operand from a mix of classes. Most are moderate normal numbers so that
  // sums neither overflow at once nor vanish, and the rest cover every other encoding.
  function automatic logic [31:0] pick_operand();
    int unsigned sel;
    logic        sgn;
    sel = $urandom_range(99);
    sgn = 1'($urandom_range(1));
    if (sel < 3) return {sgn, 8'hFF, ($urandom_range(1) ? 23'($urandom) : 23'd0)};
    if (sel < 8) return {sgn, 31'd0};
    if (sel < 16) return {sgn, 8'd0, 23'($urandom)};
    if (sel < 24) return $urandom;
    if (sel < 30) return {sgn, 8'($urandom_range(200, 254)), 23'($urandom)};
    if (sel < 36) return {sgn, 8'($urandom_range(1, 40)), 23'($urandom)};
    return {sgn, 8'($urandom_range(110, 144)), 23'($urandom)};
  endfunction

  // Sends whole vectors of random pairs until the given number of pairs has gone.
  // Some vectors repeat their first half with one factor negated, so that the sum
  // cancels towards zero and the low-order rounding is exercised.
  task automatic send_random_vectors(int unsigned count);
    int unsigned len;
    int unsigned stop_at;
    logic [31:0] av[$];
    logic [31:0] bv[$];
    stop_at = pairs_sent + count;
    while (pairs_sent < stop_at) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      av.delete();
      bv.delete();
      if ($urandom_range(9) == 0) begin
        for (int unsigned i = 0; i < (len + 1) / 2; i++) begin
          av.push_back(pick_operand());
          bv.push_back(pick_operand());
        end
        for (int unsigned i = 0; i < (len + 1) / 2; i++) begin
          av.push_back(av[i]);
          bv.push_back(bv[i] ^ 32'h8000_0000);
        end
      end else begin
        for (int unsigned i = 0; i < len; i++) begin
          av.push_back(pick_operand());
          bv.push_back(pick_operand());
        end
      end
      foreach (av[i]) send_pair(av[i], bv[i], i == av.size() - 1);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    a_value_i      = '0;
    b_value_i      = '0;
    last_element_i = 1'b0;
    send_idle_pct  = 26;
    recv_idle_pct  = 69;
    pairs_sent     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed vectors: a plain single-element product, overflow of a single product,
    // NaN and infinity inputs, subnormal underflow, signed zeros, exact cancellation,
    // an overflowing sum, a tie in rounding and the all-ones patterns.
    send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b1);
    send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
    send_pair(32'h3F80_0000, 32'h7FC0_0001, 1'b0);
    send_pair(32'h4000_0000, 32'h4000_0000, 1'b1);
    send_pair(32'hFF80_0000, 32'h0000_0000, 1'b1);
    send_pair(32'h0000_0001, 32'h0000_0001, 1'b1);
    send_pair(32'h007F_FFFF, 32'h3F80_0000, 1'b0);
    send_pair(32'h0000_0001, 32'hBF00_0000, 1'b1);
    send_pair(32'h0000_0000, 32'h8000_0000, 1'b1);
    send_pair(32'h8000_0000, 32'h3F80_0000, 1'b1);
    send_pair(32'h4040_0000, 32'h4000_0000, 1'b0);
    send_pair(32'hC040_0000, 32'h4000_0000, 1'b1);
    send_pair(32'h7F7F_FFFF, 32'h3F80_0000, 1'b0);
    send_pair(32'h7F7F_FFFF, 32'h3F80_0000, 1'b1);
    send_pair(32'h3F80_0001, 32'h3F80_0001, 1'b0);
    send_pair(32'h3380_0000, 32'h3F80_0000, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'h3F80_0000, 32'h7F80_0000, 1'b0);
    send_pair(32'h3F80_0000, 32'hFF80_0000, 1'b0);
    send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b1);
    send_pair(32'h0080_0000, 32'h3F00_0000, 1'b1);

    send_random_vectors(477);
    send_idle_pct = 69;
    recv_idle_pct = 26;
    send_random_vectors(477);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_vectors(477);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (dot_board.pending_dots.size() != 0) @(posedge clk_i);
    // The wait below catches any stray result after the last expected one.
    repeat (10) @(posedge clk_i);
    if (dot_board.failures == 0) begin
      $display("** float_dot_product_checked: PASSED **");
    end else begin
      $display("** float_dot_product_checked: FAILED **");
    end
    $finish;
  end

  // Safety net: the slowest correct run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("** float_dot_product_checked: FAILED **");
    $finish;
  end
endmodule

// File: sim.f
design/fdp_pkg.sv
design/float_dot_product_checked.sv
test/tb_top.sv
